### hdl/double_ended_queue_top_macros.svh
// ----------------------------------------------------------------------------
// double-ended queue assertion macros
// shared checks for the deque top level, clocked on clk, idle in reset
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define DEQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed in same cycle");

// consequent holds in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed one cycle later");

`endif

### hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// types and codes shared by the double-ended queue modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  // fixed widths of the word ports
  localparam int VAL_W  = 32;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_HEAD = 2'd0,
    MODE_POP_HEAD  = 2'd1,
    MODE_PUSH_TAIL = 2'd2,
    MODE_POP_TAIL  = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // controller states
  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_SEEK = 1'b1
  } ctl_state_t;

endpackage

`default_nettype wire

### hdl/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// one storage cell of the circulating chain: takes its neighbor's word or a load
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_cell #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic [WORD_BITS-1:0] shift_in,
  input  wire logic [WORD_BITS-1:0] load_in,
  input  wire logic                 load_en,
  output logic      [WORD_BITS-1:0] q
);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  // load replaces the circulating word
  always_comb begin
    word_nxt = load_en ? load_in : shift_in;
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule

`default_nettype wire

### hdl/deq_ring.sv
// ----------------------------------------------------------------------------
// deq_ring
// chain of cells that rotates the whole store one slot per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ring #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [WORD_BITS-1:0] wr_data,
  output logic      [WORD_BITS-1:0] tap
);

  logic [WORD_BITS-1:0] cell_q [DEPTH];

  // cell 0 is the access port; the last cell closes the loop or takes a write
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      deq_cell #(.WORD_BITS(WORD_BITS)) u_cell (
        .clk      (clk),
        .shift_in (cell_q[0]),
        .load_in  (wr_data),
        .load_en  (wr_en),
        .q        (cell_q[i])
      );
    end else begin : g_mid
      deq_cell #(.WORD_BITS(WORD_BITS)) u_cell (
        .clk      (clk),
        .shift_in (cell_q[i+1]),
        .load_in  (wr_data),
        .load_en  (1'b0),
        .q        (cell_q[i])
      );
    end
  end

  assign tap = cell_q[0];

endmodule

`default_nettype wire

### hdl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// head/fill bookkeeping, slot tracking on the rotating chain and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl
  import deq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32,
  parameter int CNT_W     = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // operation channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [MODE_W-1:0]    in_mode,
  input  wire logic signed [VAL_W-1:0] in_push_value,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [VAL_W-1:0]   out_pop_value,
  output logic [STAT_W-1:0]         out_status,
  output logic [CNT_W-1:0]          out_element_count,
  output logic                      out_is_empty,
  // chain port
  output logic                      ring_wr_en,
  output logic [WORD_BITS-1:0]      ring_wr_data,
  input  wire logic [WORD_BITS-1:0] ring_tap
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

  ctl_state_t           state_r, state_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic [IDX_W-1:0]     front_r, front_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  mode_t                mode_r;
  logic [WORD_BITS-1:0] value_r;
  logic [IDX_W-1:0]     slot_r;
  logic                 refused_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] pop_r;
  status_t              status_r;
  logic [CNT_W-1:0]     count_r;

  mode_t                mode_in;
  logic                 accept;
  logic                 finish;
  logic                 out_free;
  logic                 hit;
  logic                 is_full;
  logic                 is_void;
  logic [SUM_W-1:0]     sum_push;
  logic [SUM_W-1:0]     sum_pop;
  logic [IDX_W-1:0]     tail_push_slot;
  logic [IDX_W-1:0]     tail_pop_slot;
  logic [IDX_W-1:0]     head_push_slot;
  logic [IDX_W-1:0]     slot_sel;
  logic                 refused_sel;

  // position of the slot now sitting in cell 0
  always_comb begin
    pos_nxt = (pos_r == LAST_IDX) ? '0 : pos_r + IDX_W'(1);
  end

  // slot addressed by an incoming operation
  always_comb begin
    mode_in  = mode_t'(in_mode);
    is_full  = (fill_r == FULL_CNT);
    is_void  = (fill_r == '0);
    sum_push = SUM_W'(front_r) + SUM_W'(fill_r);
    sum_pop  = sum_push - SUM_W'(1);
    tail_push_slot = (sum_push >= DEPTH_SUM) ? IDX_W'(sum_push - DEPTH_SUM)
                                             : IDX_W'(sum_push);
    tail_pop_slot  = (sum_pop >= DEPTH_SUM) ? IDX_W'(sum_pop - DEPTH_SUM)
                                            : IDX_W'(sum_pop);
    head_push_slot = (front_r == '0) ? LAST_IDX : front_r - IDX_W'(1);
    case (mode_in)
      MODE_PUSH_HEAD: begin
        slot_sel    = head_push_slot;
        refused_sel = is_full;
      end
      MODE_POP_HEAD: begin
        slot_sel    = front_r;
        refused_sel = is_void;
      end
      MODE_PUSH_TAIL: begin
        slot_sel    = tail_push_slot;
        refused_sel = is_full;
      end
      default: begin
        slot_sel    = tail_pop_slot;
        refused_sel = is_void;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CTL_IDLE: if (in_valid) state_nxt = CTL_SEEK;
      CTL_SEEK: if (finish) state_nxt = CTL_IDLE;
      default:  state_nxt = CTL_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    hit      = (pos_r == slot_r);
    in_stall = 1'b1;
    accept   = 1'b0;
    finish   = 1'b0;
    unique case (state_r)
      CTL_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      CTL_SEEK: begin
        finish = (refused_r || hit) && out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    ring_wr_en   = finish && !refused_r &&
                   ((mode_r == MODE_PUSH_HEAD) || (mode_r == MODE_PUSH_TAIL));
    ring_wr_data = value_r;
  end

  // head and fill after the operation completes
  always_comb begin
    front_nxt = front_r;
    fill_nxt  = fill_r;
    if (!refused_r) begin
      case (mode_r)
        MODE_PUSH_HEAD: begin
          front_nxt = slot_r;
          fill_nxt  = fill_r + CNT_W'(1);
        end
        MODE_POP_HEAD: begin
          front_nxt = (slot_r == LAST_IDX) ? '0 : slot_r + IDX_W'(1);
          fill_nxt  = fill_r - CNT_W'(1);
        end
        MODE_PUSH_TAIL: begin
          fill_nxt = fill_r + CNT_W'(1);
        end
        default: begin
          fill_nxt = fill_r - CNT_W'(1);
        end
      endcase
    end
  end

  // result register hand-off
  always_comb begin
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CTL_IDLE;
      pos_r       <= '0;
      front_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (finish) begin
        front_r <= front_nxt;
        fill_r  <= fill_nxt;
      end
    end
  end

  // operation capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= mode_in;
      value_r   <= WORD_BITS'($unsigned(in_push_value));
      slot_r    <= slot_sel;
      refused_r <= refused_sel;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (finish) begin
      count_r <= fill_nxt;
      if (refused_r) begin
        pop_r    <= '0;
        status_r <= ((mode_r == MODE_POP_HEAD) || (mode_r == MODE_POP_TAIL))
                    ? STAT_EMPTY : STAT_FULL;
      end else begin
        pop_r    <= ((mode_r == MODE_POP_HEAD) || (mode_r == MODE_POP_TAIL))
                    ? ring_tap : '0;
        status_r <= STAT_DONE;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pop_value     = VAL_W'($unsigned(pop_r));
  assign out_status        = status_r;
  assign out_element_count = count_r;
  assign out_is_empty      = (count_r == '0);

endmodule

`default_nettype wire

### hdl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// bounded double-ended queue of signed words on a circulating chain of cells
// ----------------------------------------------------------------------------
// Each operation word (push head, pop head, push tail, pop tail) gives one result
// word with the popped value, a status, the element count and an empty flag.
// The store is a ring of DEPTH cells that rotates one slot every cycle. Reads
// are taken at cell 0, the port cell at the front of the chain, and writes load
// the last cell in place of the word leaving cell 0. The time from acceptance
// to result is set by how far the addressed slot is from the port cell; refused
// operations (pop from empty, push into full) finish without waiting for it. One
// operation is worked on at a time, and a held result word does not block the
// next operation from being accepted. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_top_macros.svh"

module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int  DEPTH     = 16,
  parameter int  WORD_BITS = 32,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [MODE_W-1:0]       in_mode,
  input  wire logic signed [VAL_W-1:0] in_push_value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [VAL_W-1:0]      out_pop_value,
  output logic [STAT_W-1:0]            out_status,
  output logic [CNT_W-1:0]             out_element_count,
  output logic                         out_is_empty
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic                 ring_wr_en;
  logic [WORD_BITS-1:0] ring_wr_data;
  logic [WORD_BITS-1:0] ring_tap;

  // bookkeeping and result register
  deq_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_push_value     (in_push_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pop_value     (out_pop_value),
    .out_status        (out_status),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty),
    .ring_wr_en        (ring_wr_en),
    .ring_wr_data      (ring_wr_data),
    .ring_tap          (ring_tap)
  );

  // rotating storage chain
  deq_ring #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_data (ring_wr_data),
    .tap     (ring_tap)
  );

  // checks
  `DEQ_ASSERT_SAME(a_empty_flag, out_valid, out_is_empty == (out_element_count == '0))
  `DEQ_ASSERT_SAME(a_count_bound, out_valid, out_element_count <= FULL_CNT)
  `DEQ_ASSERT_SAME(a_full_count, out_valid && out_status == STAT_FULL, out_element_count == FULL_CNT)
  `DEQ_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: double-ended queue testbench
// Drives push/pop words on both ends of the queue with random gaps, tracks the
// expected ring contents in a small scoreboard and checks every result word in
// order. Covers empty and full refusals, back-pressure and a drain of all pending results.
// ----------------------------------------------------------------------------

module tb_top
  import deq_pkg::*;
;

  localparam int QDEPTH        = 16;
  localparam int IDX_W         = $clog2(QDEPTH);
  localparam int CNT_W         = $clog2(QDEPTH + 1);
  localparam int RANDOM_OPS    = 1350;
  localparam int DRAIN_AT      = 675;
  localparam int HOLD_AT       = 400;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 5000;

  localparam logic signed [VAL_W-1:0] CORNER_VALS [7] = '{
    32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, 32'shffff_ffff,
    32'sh0000_0001, 32'sh5555_5555, 32'shaaaa_aaaa
  };

  typedef struct {
    logic signed [VAL_W-1:0] pop_value;
    status_t                 status;
    logic [CNT_W-1:0]        element_count;
    logic                    is_empty;
  } deq_result_t;

  // tracks queue contents and the result words still owed by the block
  class deque_tracker;
    logic signed [VAL_W-1:0] ring [QDEPTH];
    logic [IDX_W-1:0]        head;
    logic [CNT_W-1:0]        fill;
    deq_result_t             awaited[$];
    int                      errors;

    function new();
      head   = '0;
      fill   = '0;
      errors = 0;
    endfunction

    // accepted operation word: update the ring and queue the expected result
    function void apply_op(mode_t mode, logic signed [VAL_W-1:0] value);
      deq_result_t      want;
      logic [IDX_W-1:0] slot;
      want.pop_value = '0;
      want.status    = STAT_DONE;
      case (mode)
        MODE_PUSH_HEAD: begin
          if (fill == QDEPTH) begin
            want.status = STAT_FULL;
          end else begin
            head       = head - 1'b1;
            ring[head] = value;
            fill++;
          end
        end
        MODE_POP_HEAD: begin
          if (fill == 0) begin
            want.status = STAT_EMPTY;
          end else begin
            want.pop_value = ring[head];
            head           = head + 1'b1;
            fill--;
          end
        end
        MODE_PUSH_TAIL: begin
          if (fill == QDEPTH) begin
            want.status = STAT_FULL;
          end else begin
            slot       = head + fill[IDX_W-1:0];
            ring[slot] = value;
            fill++;
          end
        end
        default: begin
          if (fill == 0) begin
            want.status = STAT_EMPTY;
          end else begin
            // a full queue wraps fill to zero here, giving head - 1
            slot           = head + fill[IDX_W-1:0] - 1'b1;
            want.pop_value = ring[slot];
            fill--;
          end
        end
      endcase
      want.element_count = fill;
      want.is_empty      = (fill == 0);
      awaited.push_back(want);
    endfunction

    // accepted result word: compare against the oldest expectation
    function void match_result(logic signed [VAL_W-1:0] pop_value,
                               logic [STAT_W-1:0] status,
                               logic [CNT_W-1:0] element_count,
                               logic is_empty);
      deq_result_t want;
      if (awaited.size() == 0) begin
        $error("result word with no operation outstanding");
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (pop_value !== want.pop_value) begin
        $error("pop_value: expected %0d, actual %0d", want.pop_value, pop_value);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (element_count !== want.element_count) begin
        $error("element_count: expected %0d, actual %0d", want.element_count,
               element_count);
        errors++;
      end
      if (is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, actual %0d", want.is_empty, is_empty);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic [MODE_W-1:0]       in_mode       = MODE_PUSH_HEAD;
  logic signed [VAL_W-1:0] in_push_value = '0;
  logic                    out_valid;
  logic                    out_stall     = 1'b1;
  logic signed [VAL_W-1:0] out_pop_value;
  logic [STAT_W-1:0]       out_status;
  logic [CNT_W-1:0]        out_element_count;
  logic                    out_is_empty;

  logic                    tx_calm       = 1'b0;
  deque_tracker            sb;

  double_ended_queue_top #(
    .DEPTH     (QDEPTH),
    .WORD_BITS (VAL_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_push_value     (in_push_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pop_value     (out_pop_value),
    .out_status        (out_status),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one operation word after a random gap, hold it until accepted
  task automatic send_word(mode_t mode, logic signed [VAL_W-1:0] value);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_push_value <= value;
    do @(posedge clk); while (in_stall);
    sb.apply_op(mode, value);
  endtask

  // stimulus
  initial begin
    int                      n;
    int                      push_pct;
    int                      waited;
    logic signed [VAL_W-1:0] v;
    mode_t                   m;
    sb       = new();
    push_pct = 50;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // refusals on an empty queue
    send_word(MODE_POP_HEAD, 32'sh0);
    send_word(MODE_POP_TAIL, 32'sh0);
    // both ends, last element leaves by either pop
    send_word(MODE_PUSH_HEAD, CORNER_VALS[0]);
    send_word(MODE_PUSH_TAIL, CORNER_VALS[1]);
    send_word(MODE_POP_TAIL, 32'sh0);
    send_word(MODE_POP_HEAD, 32'sh0);
    // one element pushed at the head, taken from the tail
    send_word(MODE_PUSH_HEAD, CORNER_VALS[3]);
    send_word(MODE_POP_TAIL, 32'sh0);
    // fill to the limit from alternating ends, then refused pushes
    for (n = 0; n < QDEPTH; n++) begin
      v = (n < 7) ? CORNER_VALS[n] : $urandom;
      send_word(n[0] ? MODE_PUSH_TAIL : MODE_PUSH_HEAD, v);
    end
    send_word(MODE_PUSH_HEAD, CORNER_VALS[5]);
    send_word(MODE_PUSH_TAIL, CORNER_VALS[6]);

    // random walk with phases leaning toward push or pop
    for (n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 20;
          1:       push_pct = 50;
          default: push_pct = 80;
        endcase
      end
      if (n % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      // let all outstanding result words drain once
      if (n == DRAIN_AT) begin
        @(negedge clk) in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < push_pct) begin
        m = $urandom_range(0, 1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD;
      end else begin
        m = $urandom_range(0, 1) ? MODE_POP_TAIL : MODE_POP_HEAD;
      end
      v = ($urandom_range(0, 7) == 0) ? CORNER_VALS[$urandom_range(0, 6)] : $urandom;
      send_word(m, v);
    end

    // wait for outstanding results, then let the bench settle before the final check
    @(negedge clk) in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d result words never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off to back the queue up
  initial begin
    int   w;
    int   got;
    logic rx_calm;
    got     = 0;
    rx_calm = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (got % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      w = rx_calm ? 0 : $urandom_range(0, 19);
      if (got == HOLD_AT) w = LONG_HOLD;
      @(negedge clk);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.match_result(out_pop_value, out_status, out_element_count, out_is_empty);
      got++;
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
